// File: sv/dfd_pkg.sv
// Displacement frame decoder: shared types, constants and the byte-slot decode.
// Used by every design module of the block; depends on nothing else.
`timescale 1ns / 1ps

package dfd_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'hA3;
  localparam logic [7:0] VERSION_BYTE  = 8'h01;
  localparam int unsigned HEADER_POS   = 0;
  localparam int unsigned VERSION_POS  = 6;
  localparam int unsigned FIRST_COUNT  = 7;
  localparam int unsigned SLOT_BYTES   = 6;
  localparam int unsigned COUNT_BYTES  = 5;
  localparam int unsigned BASE_AXES    = 5;
  localparam int unsigned AXES_LIMIT   = 6;

  localparam int unsigned COUNT_W = 37;
  localparam int unsigned POS_W   = 45;
  localparam int unsigned SUM_W   = 62;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned PROD_W  = COUNT_W + GAIN_W;
  localparam int unsigned FRAMES_W = 16;
  localparam int unsigned DIVSR_W = FRAMES_W + 1;

  localparam logic [1:0] REG_SIX_AXIS = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_COLLECT  = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET    = 32'h0100_0000;
  localparam logic [FRAMES_W-1:0] COLLECT_RESET = 16'd1;

  typedef struct packed {
    logic       hit;
    logic [2:0] ax;
    logic [2:0] j;
  } slot_t;

  typedef struct packed {
    logic       load;
    logic       mul_lo;
    logic       mul_hi;
    logic       combine;
    logic       finish;
    logic       emit;
    logic       last;
    logic       div_start;
    logic       emit_avg;
    logic [2:0] axis;
  } cmd_t;

  typedef struct packed {
    logic frame_accept;
    logic six_mode;
    logic avg_due;
    logic out_free;
    logic div_busy;
  } status_t;

  // Which count and which byte of it a datagram byte position holds.
  function automatic slot_t slot_decode(input logic [5:0] p);
    slot_t      s;
    logic [5:0] q;
    s = '0;
    q = p - 6'(FIRST_COUNT);
    for (int k = 0; k < AXES_LIMIT; k++) begin
      if (p >= 6'(FIRST_COUNT) && q >= 6'(SLOT_BYTES * k) && q < 6'(SLOT_BYTES * k + SLOT_BYTES))
      begin
        s.ax = 3'(k);
        s.j  = 3'(q - 6'(SLOT_BYTES * k));
        s.hit = (3'(q - 6'(SLOT_BYTES * k)) < 3'(COUNT_BYTES));
      end
    end
    return s;
  endfunction

endpackage

// File: sv/displacement_frame_decoder.sv
// Displacement frame decoder, top level: joins the sequencer and the datapath.
// Depends on dfd_pkg, dfd_ctrl, dfd_dp, dfd_div.
//
// Input channel: one datagram byte per word (data_byte_i, frame_end_i on the
// last byte), valid/stall. Bytes are taken one per cycle while receiving.
// After the last byte of a datagram with a good header and enough length the
// input stalls while each axis is scaled in turn (load, two 37x16
// multiplies, combine, sign/shift/saturate, emit), plus any output stall.
// When an average is due, the axes are followed by the divider start,
// 62 one-bit divide steps, a wait state that sees the divider finish, then
// the average word is loaded; input reopens after the final word is loaded
// into the output register. Rejected datagrams do not stall the input.
// Output channel: one result per word, valid/stall, held by a single output
// register; a stalled word keeps its value and holds up the sequencer.
// Configuration: cfg_valid_i/cfg_ready_o, always ready; write while idle.
// Reset (rst_ni low, async) clears byte position, header flag, sums, frame
// count and configuration to their defaults; the count registers are not
// cleared.
`timescale 1ns / 1ps

module displacement_frame_decoder #(
  parameter int unsigned MAX_AXES           = 6,
  parameter int unsigned GAIN_FRACTION_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 frame_end_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 result_kind_o,
  output logic [2:0]                           axis_index_o,
  output logic signed [dfd_pkg::COUNT_W-1:0]   raw_count_o,
  output logic signed [dfd_pkg::POS_W-1:0]     position_o,
  output logic signed [dfd_pkg::POS_W-1:0]     average_first_o,
  output logic signed [dfd_pkg::POS_W-1:0]     average_second_o,
  output logic                                 last_result_o
);

  dfd_pkg::cmd_t    cmd;
  dfd_pkg::status_t status;
  logic             in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;

  dfd_ctrl #(.MAX_AXES(MAX_AXES)) u_ctrl (
    .clk_i, .rst_ni, .status_i(status), .cmd_o(cmd), .in_stall_o
  );

  dfd_dp #(.MAX_AXES(MAX_AXES), .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .in_acc_i(in_acc), .data_byte_i, .frame_end_i,
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_stall_i, .out_valid_o, .result_kind_o, .axis_index_o, .raw_count_o,
    .position_o, .average_first_o, .average_second_o, .last_result_o
  );

endmodule

// File: sv/dfd_div.sv
// Restoring divider, one quotient bit per cycle, for the pair-sum averages.
// Depends on dfd_pkg for widths.
`timescale 1ns / 1ps

module dfd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [dfd_pkg::SUM_W-1:0]       dividend_i,
  input  logic [dfd_pkg::DIVSR_W-1:0]     divisor_i,
  output logic                            busy_o,
  output logic [dfd_pkg::SUM_W-1:0]       quotient_o
);

  localparam int unsigned CNT_W = $clog2(dfd_pkg::SUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(dfd_pkg::SUM_W - 1);

  logic                          busy_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [dfd_pkg::SUM_W-1:0]     quo_q;
  logic [dfd_pkg::DIVSR_W-1:0]   rem_q;
  logic [dfd_pkg::DIVSR_W-1:0]   dvs_q;
  logic [dfd_pkg::DIVSR_W:0]     trial;
  logic                          ge;

  assign trial = {rem_q, quo_q[dfd_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? dfd_pkg::DIVSR_W'(trial - {1'b0, dvs_q}) : trial[dfd_pkg::DIVSR_W-1:0];
      quo_q <= {quo_q[dfd_pkg::SUM_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/dfd_ctrl.sv
// Sequencer for the decoder: receive bytes, then scale and emit each axis,
// then run the average when one is due. Depends on dfd_pkg for the command and status structs.
`timescale 1ns / 1ps

module dfd_ctrl #(
  parameter int unsigned MAX_AXES = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfd_pkg::status_t  status_i,
  output dfd_pkg::cmd_t     cmd_o,
  output logic              in_stall_o
);

  typedef enum logic [3:0] {
    ST_RECV, ST_LOAD, ST_MUL_LO, ST_MUL_HI, ST_COMBINE, ST_FINISH, ST_EMIT,
    ST_DIV_START, ST_DIV_WAIT, ST_EMIT_AVG
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] axis_q, axis_d;
  logic [2:0] last_ax;
  logic       is_last_ax;

  assign last_ax    = status_i.six_mode ? 3'(MAX_AXES - 1) : 3'(dfd_pkg::BASE_AXES - 1);
  assign is_last_ax = (axis_q == last_ax);

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    cmd_o.last = is_last_ax && !status_i.avg_due;
    unique case (state_q)
      ST_RECV: begin
        if (status_i.frame_accept) begin
          axis_d  = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = ST_COMBINE;
      end
      ST_COMBINE: begin
        cmd_o.combine = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!is_last_ax) begin
            axis_d  = axis_q + 1'b1;
            state_d = ST_LOAD;
          end else if (status_i.avg_due) begin
            state_d = ST_DIV_START;
          end else begin
            state_d = ST_RECV;
          end
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) state_d = ST_EMIT_AVG;
      end
      ST_EMIT_AVG: begin
        if (status_i.out_free) begin
          cmd_o.emit_avg = 1'b1;
          state_d = ST_RECV;
        end
      end
      default: state_d = ST_RECV;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  assign in_stall_o = (state_q != ST_RECV);

endmodule

// File: sv/dfd_dp.sv
// Datapath: byte capture, gain multiply, pair sums, average and output register.
// Depends on dfd_pkg and dfd_div.
`timescale 1ns / 1ps

module dfd_dp #(
  parameter int unsigned MAX_AXES           = 6,
  parameter int unsigned GAIN_FRACTION_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dfd_pkg::cmd_t                        cmd_i,
  output dfd_pkg::status_t                     status_o,
  input  logic                                 in_acc_i,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 frame_end_i,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 result_kind_o,
  output logic [2:0]                           axis_index_o,
  output logic signed [dfd_pkg::COUNT_W-1:0]   raw_count_o,
  output logic signed [dfd_pkg::POS_W-1:0]     position_o,
  output logic signed [dfd_pkg::POS_W-1:0]     average_first_o,
  output logic signed [dfd_pkg::POS_W-1:0]     average_second_o,
  output logic                                 last_result_o
);

  localparam int unsigned AXW = $clog2(MAX_AXES);
  localparam int unsigned CW  = dfd_pkg::COUNT_W;
  localparam int unsigned PW  = dfd_pkg::POS_W;
  localparam int unsigned SW  = dfd_pkg::SUM_W;
  localparam int unsigned HW  = dfd_pkg::HALF_W;
  localparam int unsigned MW  = CW + HW;
  localparam int unsigned XW  = dfd_pkg::PROD_W;
  localparam logic [6:0] NEED_SIX  = 7'(dfd_pkg::SLOT_BYTES * MAX_AXES + 6);
  localparam logic [6:0] NEED_FIVE = 7'(dfd_pkg::SLOT_BYTES * dfd_pkg::BASE_AXES + 6);

  // configuration
  logic                         six_q;
  logic [dfd_pkg::GAIN_W-1:0]   gain_q;
  logic [dfd_pkg::FRAMES_W-1:0] collect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      six_q     <= 1'b0;
      gain_q    <= dfd_pkg::GAIN_RESET;
      collect_q <= dfd_pkg::COLLECT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dfd_pkg::REG_SIX_AXIS: six_q     <= cfg_data_i[0];
        dfd_pkg::REG_GAIN:     gain_q    <= cfg_data_i;
        dfd_pkg::REG_COLLECT:  collect_q <= cfg_data_i[dfd_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // byte capture
  logic [5:0]     pos_q;
  logic           hg_q, hg_d;
  logic [CW-1:0]  axis_q [MAX_AXES];
  dfd_pkg::slot_t slot;
  logic [6:0]     need;

  assign slot = dfd_pkg::slot_decode(pos_q);
  assign need = six_q ? NEED_SIX : NEED_FIVE;

  always_comb begin
    hg_d = hg_q;
    if (pos_q == 6'(dfd_pkg::HEADER_POS)) hg_d = (data_byte_i == dfd_pkg::HEADER_BYTE);
    else if (pos_q == 6'(dfd_pkg::VERSION_POS))
      hg_d = hg_q && (data_byte_i == dfd_pkg::VERSION_BYTE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hg_q  <= 1'b0;
    end else if (in_acc_i) begin
      if (frame_end_i) begin
        pos_q <= '0;
        hg_q  <= 1'b0;
      end else begin
        hg_q <= hg_d;
        if (pos_q != 6'h3F) pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && slot.hit && (32'(slot.ax) < MAX_AXES)) begin
      unique case (slot.j)
        3'd0: axis_q[slot.ax[AXW-1:0]][7:0]   <= data_byte_i;
        3'd1: axis_q[slot.ax[AXW-1:0]][15:8]  <= data_byte_i;
        3'd2: axis_q[slot.ax[AXW-1:0]][23:16] <= data_byte_i;
        3'd3: axis_q[slot.ax[AXW-1:0]][31:24] <= data_byte_i;
        default: axis_q[slot.ax[AXW-1:0]][CW-1:32] <= data_byte_i[CW-33:0];
      endcase
    end
  end

  logic frame_accept;
  assign frame_accept = in_acc_i && frame_end_i && hg_d && ({1'b0, pos_q} + 7'd1 >= need);

  // scaling: |count| * gain in two 16-bit halves, then sign, shift and saturate
  logic signed [CW-1:0] cnt_q;
  logic [CW-1:0]        mag_q;
  logic                 neg_q;
  logic [MW-1:0]        lo_q, hi_q;
  logic [XW-1:0]        prod_q;
  logic signed [PW-1:0] posr_q;
  logic signed [XW:0]   sgn;
  logic signed [XW:0]   shr;
  logic signed [PW-1:0] sat;
  logic signed [CW-1:0] rd;

  assign rd  = axis_q[cmd_i.axis[AXW-1:0]];
  assign sgn = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign shr = sgn >>> GAIN_FRACTION_BITS;

  always_comb begin
    if (shr[XW:PW-1] == '0 || shr[XW:PW-1] == '1) sat = shr[PW-1:0];
    else if (shr[XW]) sat = {1'b1, {(PW-1){1'b0}}};
    else sat = {1'b0, {(PW-1){1'b1}}};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q <= rd;
      neg_q <= rd[CW-1];
      mag_q <= rd[CW-1] ? CW'(-rd) : rd;
    end
    if (cmd_i.mul_lo)  lo_q <= MW'(mag_q * gain_q[HW-1:0]);
    if (cmd_i.mul_hi)  hi_q <= MW'(mag_q * gain_q[2*HW-1:HW]);
    if (cmd_i.combine) prod_q <= {hi_q, {HW{1'b0}}} + XW'(lo_q);
    if (cmd_i.finish)  posr_q <= sat;
  end

  // pair sums and frame count
  logic signed [SW-1:0]         sum1_q, sum2_q;
  logic [dfd_pkg::FRAMES_W-1:0] frames_q;
  logic [dfd_pkg::FRAMES_W-1:0] eff_collect;
  logic signed [SW-1:0]         pos_ext;

  assign eff_collect = (collect_q == '0) ? dfd_pkg::FRAMES_W'(1) : collect_q;
  assign pos_ext     = SW'(posr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum1_q   <= '0;
      sum2_q   <= '0;
      frames_q <= '0;
    end else if (cmd_i.emit_avg) begin
      sum1_q   <= '0;
      sum2_q   <= '0;
      frames_q <= '0;
    end else begin
      if (frame_accept) frames_q <= frames_q + 1'b1;
      if (cmd_i.emit) begin
        if (cmd_i.axis < 3'd2) sum1_q <= sum1_q + pos_ext;
        else if (cmd_i.axis < 3'd4) sum2_q <= sum2_q + pos_ext;
      end
    end
  end

  // averages
  logic                 n1_q, n2_q;
  logic                 b1, b2;
  logic [SW-1:0]        q1, q2;
  logic [dfd_pkg::DIVSR_W-1:0] dvs;

  assign dvs = {frames_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      n1_q <= sum1_q[SW-1];
      n2_q <= sum2_q[SW-1];
    end
  end

  dfd_div u_div_first (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .dividend_i(sum1_q[SW-1] ? SW'(-sum1_q) : sum1_q),
    .divisor_i(dvs), .busy_o(b1), .quotient_o(q1)
  );

  dfd_div u_div_second (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .dividend_i(sum2_q[SW-1] ? SW'(-sum2_q) : sum2_q),
    .divisor_i(dvs), .busy_o(b2), .quotient_o(q2)
  );

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit || cmd_i.emit_avg) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_kind_o    <= 1'b0;
      axis_index_o     <= cmd_i.axis;
      raw_count_o      <= cnt_q;
      position_o       <= posr_q;
      average_first_o  <= '0;
      average_second_o <= '0;
      last_result_o    <= cmd_i.last;
    end else if (cmd_i.emit_avg) begin
      result_kind_o    <= 1'b1;
      axis_index_o     <= '0;
      raw_count_o      <= '0;
      position_o       <= '0;
      average_first_o  <= PW'(n1_q ? -q1 : q1);
      average_second_o <= PW'(n2_q ? -q2 : q2);
      last_result_o    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.frame_accept = frame_accept;
  assign status_o.six_mode     = six_q;
  assign status_o.avg_due      = (frames_q >= eff_collect);
  assign status_o.out_free     = !out_valid_q || !out_stall_i;
  assign status_o.div_busy     = b1 || b2;

endmodule

// File: sv/dfd_checker.sv
// Port-level checks for the displacement frame decoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module dfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [2:0]  axis_index_o,
  input logic [36:0] raw_count_o,
  input logic [44:0] position_o,
  input logic [44:0] average_first_o,
  input logic [44:0] average_second_o,
  input logic        last_result_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o))
    else $error("stalled word dropped or changed");

  a_avg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> last_result_o)
    else $error("average word not marked last");

  a_avg_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |->
      axis_index_o == 3'd0 && raw_count_o == '0 && position_o == '0)
    else $error("average word carries axis fields");

  a_axis_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |->
      axis_index_o <= 3'd5 && average_first_o == '0 && average_second_o == '0)
    else $error("axis word malformed");

endmodule

bind displacement_frame_decoder dfd_checker u_dfd_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .result_kind_o, .axis_index_o,
  .raw_count_o, .position_o, .average_first_o, .average_second_o, .last_result_o
);
